>>> rtl/core/mte_pkg.sv
package mte_pkg;

    localparam int FIELD_BITS = 32;

    localparam logic [1:0] REQ_LOAD_A    = 2'd0;
    localparam logic [1:0] REQ_LOAD_B    = 2'd1;
    localparam logic [1:0] REQ_TRANSFORM = 2'd2;
    localparam logic [1:0] REQ_PRODUCT   = 2'd3;

    localparam logic RES_KIND_VECTOR = 1'b0;
    localparam logic RES_KIND_MATRIX = 1'b1;

    typedef struct packed {
        logic        [1:0]            req_type;
        logic        [1:0]            elem_row;
        logic        [1:0]            elem_col;
        logic signed [FIELD_BITS-1:0] elem_value;
        logic signed [FIELD_BITS-1:0] vec_x;
        logic signed [FIELD_BITS-1:0] vec_y;
        logic signed [FIELD_BITS-1:0] vec_z;
        logic signed [FIELD_BITS-1:0] vec_w;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] res_x;
        logic signed [FIELD_BITS-1:0] res_y;
        logic signed [FIELD_BITS-1:0] res_z;
        logic signed [FIELD_BITS-1:0] res_w;
        logic        [1:0]            res_row;
        logic                         res_kind;
        logic                         res_saturated;
        logic                         res_last;
    } res_t;

endpackage

>>> rtl/core/matrix4_transform_engine.sv
// matrix4_transform_engine
// Signed fixed-point 4x4 matrix engine with stored matrices A and B.
// Request channel (req_valid/req_ready/req_data): load an element of A or
// B, transform a vector by A, or multiply A by B. Result channel
// (res_valid/res_ready/res_data): one result per transform, four per
// product (one per row, res_last on row 3). Loads give no result.
// Loads can be issued back to back.
// One shared multiplier (one product per cycle, registered) feeds an
// accumulator: each result needs 16 products, then a drain state that
// adds the last product and an emit state that registers the result;
// with no stalls the next request is taken on the cycle the last result
// transfers.
// req_ready is high only while the sequencer is idle.
// Each dot product is summed exactly, shifted right by FRAC_BITS (floor)
// and saturated to WORD_BITS, then sign-extended to 32 bits.
// Reset clears both matrices to zero and empties the result register.
// If the receiver stalls, a finished result waits in the output register
// and the sequencer holds before loading the next one; a new request can
// be taken while the last result of the previous one is still waiting.
module matrix4_transform_engine #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mte_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output mte_pkg::res_t res_data
);
    import mte_pkg::*;

    localparam int PROD_W = 2 * WORD_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((ACC_W'(1) << (WORD_BITS - 1)) - ACC_W'(1));
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] grp_reg, grp_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       kind_reg, kind_next;
    logic       sat_reg, sat_next;
    logic       res_valid_reg, res_valid_next;
    res_t       res_data_reg, res_data_next;

    logic signed [WORD_BITS-1:0] mat_a_reg [16];
    logic signed [WORD_BITS-1:0] mat_b_reg [16];
    logic signed [WORD_BITS-1:0] vec_reg [4];
    logic signed [WORD_BITS-1:0] vals_reg [4];

    logic                     p_vld_reg, p_vld_next;
    logic                     p_first_reg, p_last_reg;
    logic [1:0]               p_d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                    accept;
    logic                    issue;
    logic                    emit_go;
    logic                    emit_last;
    logic [1:0]              dot_idx;
    logic [1:0]              k_idx;
    logic [1:0]              a_row;
    logic signed [WORD_BITS-1:0] a_op;
    logic signed [WORD_BITS-1:0] b_op;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shifted;
    logic                    dot_sat;
    logic signed [WORD_BITS-1:0] dot_val;
    logic [3:0]              elem_idx;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign issue     = (state_reg == ST_RUN);
    assign emit_go   = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);
    assign emit_last = (kind_reg == RES_KIND_VECTOR) || (grp_reg == 2'd3);
    assign dot_idx   = cnt_reg[3:2];
    assign k_idx     = cnt_reg[1:0];
    assign a_row     = (kind_reg == RES_KIND_MATRIX) ? grp_reg : dot_idx;
    assign a_op      = mat_a_reg[{a_row, k_idx}];
    assign b_op      = (kind_reg == RES_KIND_MATRIX) ? mat_b_reg[{k_idx, dot_idx}]
                                                     : vec_reg[k_idx];
    assign elem_idx  = {req_data.elem_row, req_data.elem_col};

    assign sum     = (p_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    assign shifted = sum >>> FRAC_BITS;

    always_comb
    begin
        dot_sat = 1'b0;
        dot_val = shifted[WORD_BITS-1:0];
        if (shifted > SAT_MAX)
        begin
            dot_sat = 1'b1;
            dot_val = SAT_MAX[WORD_BITS-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            dot_sat = 1'b1;
            dot_val = SAT_MIN[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        sat_next       = sat_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        p_vld_next     = issue;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (p_vld_reg && p_last_reg && dot_sat)
        begin
            sat_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_data.req_type == REQ_TRANSFORM ||
                               req_data.req_type == REQ_PRODUCT))
                begin
                    state_next = ST_RUN;
                    grp_next   = 2'd0;
                    cnt_next   = 4'd0;
                    sat_next   = 1'b0;
                    kind_next  = (req_data.req_type == REQ_PRODUCT) ? RES_KIND_MATRIX
                                                                    : RES_KIND_VECTOR;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    res_valid_next              = 1'b1;
                    res_data_next.res_x         = FIELD_BITS'(vals_reg[0]);
                    res_data_next.res_y         = FIELD_BITS'(vals_reg[1]);
                    res_data_next.res_z         = FIELD_BITS'(vals_reg[2]);
                    res_data_next.res_w         = FIELD_BITS'(vals_reg[3]);
                    res_data_next.res_row       = (kind_reg == RES_KIND_MATRIX) ? grp_reg
                                                                                : 2'd0;
                    res_data_next.res_kind      = kind_reg;
                    res_data_next.res_saturated = sat_reg;
                    res_data_next.res_last      = emit_last;
                    sat_next                    = 1'b0;
                    cnt_next                    = 4'd0;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        grp_next   = grp_reg + 2'd1;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grp_reg       <= 2'd0;
            cnt_reg       <= 4'd0;
            kind_reg      <= RES_KIND_VECTOR;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            p_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
            p_vld_reg     <= p_vld_next;
        end
    end

    // matrix store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_a_reg[i] <= '0;
                mat_b_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (req_data.req_type == REQ_LOAD_A)
            begin
                mat_a_reg[elem_idx] <= req_data.elem_value[WORD_BITS-1:0];
            end
            else if (req_data.req_type == REQ_LOAD_B)
            begin
                mat_b_reg[elem_idx] <= req_data.elem_value[WORD_BITS-1:0];
            end
        end
    end

    // datapath: multiply stage, then accumulate stage
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        if (accept && req_data.req_type == REQ_TRANSFORM)
        begin
            vec_reg[0] <= req_data.vec_x[WORD_BITS-1:0];
            vec_reg[1] <= req_data.vec_y[WORD_BITS-1:0];
            vec_reg[2] <= req_data.vec_z[WORD_BITS-1:0];
            vec_reg[3] <= req_data.vec_w[WORD_BITS-1:0];
        end
        if (issue)
        begin
            prod_reg    <= a_op * b_op;
            p_first_reg <= (k_idx == 2'd0);
            p_last_reg  <= (k_idx == 2'd3);
            p_d_reg     <= dot_idx;
        end
        if (p_vld_reg)
        begin
            acc_reg <= sum;
            if (p_last_reg)
            begin
                vals_reg[p_d_reg] <= dot_val;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !p_vld_reg)
        else $error("request taken with products in flight");

    a_prod_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("product stage active outside run");

    a_vector_single: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.res_kind == RES_KIND_VECTOR)
            |-> (res_data.res_row == 2'd0 && res_data.res_last))
        else $error("transform result not single and last");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && emit_last) |=> (state_reg == ST_IDLE && res_valid))
        else $error("last result did not return to idle");

endmodule
